// ----- sv/mhtq_pkg.sv -----
// ----------------------------------------------------------------------------
// Min-heap timer queue: shared types and constants
// Entry layout, item kinds, status codes, cell control words and the
// sequencer states used by the heap cells, the pop log and the top level.
// ----------------------------------------------------------------------------
package mhtq_pkg;

    localparam int DL_W   = 48;
    localparam int ID_W   = 31;
    localparam int CTX_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DL_W-1:0]  deadline;
        logic [DL_W-1:0]  interval;
        logic [CTX_W-1:0] ctx;
    } t_entry;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_FIRE = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_FIRED    = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NO_ID    = 3'd3,
        ST_FULL     = 3'd4,
        ST_NONE_DUE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,
        OP_MOVE,
        OP_UP,
        OP_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sel;
        logic     vld;
        logic     root;
    } t_cell_ctrl;

    typedef struct packed {
        logic vld_l;
        logic vld_r;
        logic up_l;
        logic up_r;
        logic down;
    } t_cell_link;

    typedef struct packed {
        logic vld;
        logic up;
        logic take_l;
        logic take_r;
        logic match;
    } t_cell_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_UP,
        S_DEL_PICK,
        S_REM_UP,
        S_REM_DOWN,
        S_FIRE_POP,
        S_RA_RD,
        S_RA_INS,
        S_RA_UP,
        S_EM_RD,
        S_EM_OUT,
        S_REPORT
    } t_state;

endpackage

// ----- sv/min_heap_timer_queue_top.sv -----
// ----------------------------------------------------------------------------
// Min-heap timer queue: top level
// Binary min-heap of timers held in a tree of cells, with a sequencer that
// sifts one level per cycle and a pop log for fire items.
// ----------------------------------------------------------------------------
// Sequencing: an add writes the tail slot, sifts it up one level per step and
// reports; a delete moves the tail into the matching slot, sifts it up, then down,
// and reports. A full add or a fire on an empty queue gives its word in the cycle
// after acceptance. A fire pops each due timer from the root and sifts down, then
// re-adds each popped timer with a nonzero interval and sifts it up, then emits a
// fired word per popped timer. Words cannot be stalled. Reset empties the queue and
// restarts ids at zero; slot contents are left as they are.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_top #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mhtq_pkg::KIND_W-1:0] i_kind,
    input  logic [mhtq_pkg::DL_W-1:0]   i_deadline,
    input  logic [mhtq_pkg::DL_W-1:0]   i_interval,
    input  logic [mhtq_pkg::CTX_W-1:0]  i_context_req,
    input  logic [mhtq_pkg::ID_W-1:0]   i_target_id,
    output logic                        o_strobe,
    output logic [mhtq_pkg::STAT_W-1:0] o_status,
    output logic [mhtq_pkg::ID_W-1:0]   o_timer_id,
    output logic [mhtq_pkg::DL_W-1:0]   o_fired_deadline,
    output logic [mhtq_pkg::CTX_W-1:0]  o_fired_context,
    output logic [mhtq_pkg::DL_W-1:0]   o_next_deadline,
    output logic                        o_armed,
    output logic                        o_last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mhtq_pkg::t_state           r_state,  n_state;
    logic [CNT_W-1:0]           r_count,  n_count;
    logic [mhtq_pkg::ID_W-1:0]  r_next_id, n_next_id;
    logic [IDX_W-1:0]           r_pos,    n_pos;
    logic [IDX_W-1:0]           r_pos0,   n_pos0;
    logic                       r_is_fire, n_is_fire;
    logic [mhtq_pkg::DL_W-1:0]  r_earliest, n_earliest;
    logic [CNT_W-1:0]           r_npop,   n_npop;
    logic [IDX_W-1:0]           r_iter,   n_iter;
    mhtq_pkg::t_status          r_status, n_status;
    logic [mhtq_pkg::ID_W-1:0]  r_id,     n_id;
    logic [QUEUE_DEPTH-1:0]     r_match,  n_match;

    logic                       r_o_strobe,  n_o_strobe;
    mhtq_pkg::t_status          r_o_status,  n_o_status;
    logic [mhtq_pkg::ID_W-1:0]  r_o_id,      n_o_id;
    logic [mhtq_pkg::DL_W-1:0]  r_o_fired_dl, n_o_fired_dl;
    logic [mhtq_pkg::CTX_W-1:0] r_o_fired_ctx, n_o_fired_ctx;
    logic [mhtq_pkg::DL_W-1:0]  r_o_next_dl, n_o_next_dl;
    logic                       r_o_armed,   n_o_armed;
    logic                       r_o_last,    n_o_last;

    mhtq_pkg::t_entry           w_entry [QUEUE_DEPTH];
    mhtq_pkg::t_cell_stat       w_stat  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]     w_up_vec;
    logic [QUEUE_DEPTH-1:0]     w_l_vec;
    logic [QUEUE_DEPTH-1:0]     w_r_vec;
    logic [QUEUE_DEPTH-1:0]     w_match_vec;
    logic [QUEUE_DEPTH-1:0]     w_low;
    logic [IDX_W-1:0]           w_match_idx;
    logic                       w_any_up;
    logic                       w_any_l;
    logic                       w_any_r;
    logic                       w_any_match;

    mhtq_pkg::t_cell_op         w_cell_op;
    logic [IDX_W-1:0]           w_cell_pos;
    mhtq_pkg::t_entry           w_wr;
    mhtq_pkg::t_entry           w_tail;
    mhtq_pkg::t_entry           w_root;
    mhtq_pkg::t_entry           w_rd;
    logic                       w_log_we;
    logic [mhtq_pkg::DL_W:0]    w_sum;
    logic [mhtq_pkg::DL_W-1:0]  w_sat;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_iter_last;
    logic                       w_pop_due;
    logic [IDX_W-1:0]           w_par_pos;
    logic [IDX_W-1:0]           w_l_pos;
    logic [IDX_W-1:0]           w_r_pos;

    genvar gi;

    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        localparam int P = (gi == 0) ? 0 : (gi - 1) / 2;
        localparam int L = 2 * gi + 1;
        localparam int R = 2 * gi + 2;

        mhtq_pkg::t_cell_ctrl ctrl;
        mhtq_pkg::t_cell_link link;
        mhtq_pkg::t_entry     par;
        mhtq_pkg::t_entry     lft;
        mhtq_pkg::t_entry     rgt;

        assign ctrl.op   = w_cell_op;
        assign ctrl.sel  = (w_cell_pos == IDX_W'(gi));
        assign ctrl.vld  = (CNT_W'(gi) < r_count);
        assign ctrl.root = (gi == 0);

        if (gi == 0) begin : g_root
            assign par       = '0;
            assign link.down = 1'b0;
        end else begin : g_child
            assign par       = w_entry[P];
            assign link.down = (gi % 2 == 1) ? w_stat[P].take_l : w_stat[P].take_r;
        end

        if (L < QUEUE_DEPTH) begin : g_left
            assign lft        = w_entry[L];
            assign link.vld_l = w_stat[L].vld;
            assign link.up_l  = w_stat[L].up;
        end else begin : g_no_left
            assign lft        = '0;
            assign link.vld_l = 1'b0;
            assign link.up_l  = 1'b0;
        end

        if (R < QUEUE_DEPTH) begin : g_right
            assign rgt        = w_entry[R];
            assign link.vld_r = w_stat[R].vld;
            assign link.up_r  = w_stat[R].up;
        end else begin : g_no_right
            assign rgt        = '0;
            assign link.vld_r = 1'b0;
            assign link.up_r  = 1'b0;
        end

        mhtq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_link      (link),
            .i_wr        (w_wr),
            .i_tail      (w_tail),
            .i_parent    (par),
            .i_left      (lft),
            .i_right     (rgt),
            .i_target_id (i_target_id),
            .o_entry     (w_entry[gi]),
            .o_stat      (w_stat[gi])
        );

        assign w_up_vec[gi]    = w_stat[gi].up;
        assign w_l_vec[gi]     = w_stat[gi].take_l;
        assign w_r_vec[gi]     = w_stat[gi].take_r;
        assign w_match_vec[gi] = w_stat[gi].match;
    end

    mhtq_pop_log #(
        .DEPTH (QUEUE_DEPTH)
    ) u_pop_log (
        .i_clk     (i_clk),
        .i_wr_en   (w_log_we),
        .i_wr_addr (r_npop[IDX_W-1:0]),
        .i_wr_data (w_root),
        .i_rd_addr (r_iter),
        .o_rd_data (w_rd)
    );

    assign w_root      = w_entry[0];
    assign w_tail      = w_entry[IDX_W'(r_count - CNT_W'(1))];
    assign w_any_up    = |w_up_vec;
    assign w_any_l     = |w_l_vec;
    assign w_any_r     = |w_r_vec;
    assign w_any_match = |r_match;
    assign w_low       = r_match & (~r_match + QUEUE_DEPTH'(1));

    always_comb begin
        w_match_idx = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_low[i]) begin
                w_match_idx = w_match_idx | IDX_W'(i);
            end
        end
    end

    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_iter_last = (CNT_W'(r_iter) == (r_npop - CNT_W'(1)));
    assign w_pop_due   = !w_empty && (w_root.deadline == r_earliest);
    assign w_par_pos   = (r_pos - IDX_W'(1)) >> 1;
    assign w_l_pos     = IDX_W'({r_pos, 1'b1});
    assign w_r_pos     = IDX_W'({r_pos, 1'b1} + (IDX_W + 1)'(1));
    assign w_sum       = {1'b0, w_rd.deadline} + {1'b0, w_rd.interval};
    assign w_sat       = w_sum[mhtq_pkg::DL_W] ? '1 : w_sum[mhtq_pkg::DL_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_next_id  = r_next_id;
        n_pos      = r_pos;
        n_pos0     = r_pos0;
        n_is_fire  = r_is_fire;
        n_earliest = r_earliest;
        n_npop     = r_npop;
        n_iter     = r_iter;
        n_status   = r_status;
        n_id       = r_id;
        n_match    = r_match;
        unique case (r_state)
            mhtq_pkg::S_IDLE: begin
                n_match = w_match_vec;
                if (start) begin
                    unique case (i_kind)
                        mhtq_pkg::KIND_ADD: begin
                            if (!w_full) begin
                                n_count   = r_count + CNT_W'(1);
                                n_next_id = r_next_id + mhtq_pkg::ID_W'(1);
                                n_pos     = IDX_W'(r_count);
                                n_id      = r_next_id;
                                n_status  = mhtq_pkg::ST_ADDED;
                                n_state   = mhtq_pkg::S_ADD_UP;
                            end
                        end
                        mhtq_pkg::KIND_DEL: begin
                            n_id      = i_target_id;
                            n_is_fire = 1'b0;
                            n_state   = mhtq_pkg::S_DEL_PICK;
                        end
                        default: begin
                            if (!w_empty) begin
                                n_earliest = w_root.deadline;
                                n_npop     = '0;
                                n_is_fire  = 1'b1;
                                n_state    = mhtq_pkg::S_FIRE_POP;
                            end
                        end
                    endcase
                end
            end
            mhtq_pkg::S_ADD_UP: begin
                if (w_any_up) begin
                    n_pos = w_par_pos;
                end else begin
                    n_state = mhtq_pkg::S_REPORT;
                end
            end
            mhtq_pkg::S_DEL_PICK: begin
                if (w_any_match) begin
                    n_status = mhtq_pkg::ST_DELETED;
                    n_count  = r_count - CNT_W'(1);
                    n_pos    = w_match_idx;
                    n_pos0   = w_match_idx;
                    n_state  = mhtq_pkg::S_REM_UP;
                end else begin
                    n_status = mhtq_pkg::ST_NO_ID;
                    n_state  = mhtq_pkg::S_REPORT;
                end
            end
            mhtq_pkg::S_REM_UP: begin
                if (w_any_up) begin
                    n_pos = w_par_pos;
                end else begin
                    n_pos   = r_pos0;
                    n_state = mhtq_pkg::S_REM_DOWN;
                end
            end
            mhtq_pkg::S_REM_DOWN: begin
                priority if (w_any_l) begin
                    n_pos = w_l_pos;
                end else if (w_any_r) begin
                    n_pos = w_r_pos;
                end else begin
                    n_state = r_is_fire ? mhtq_pkg::S_FIRE_POP : mhtq_pkg::S_REPORT;
                end
            end
            mhtq_pkg::S_FIRE_POP: begin
                if (w_pop_due) begin
                    n_npop  = r_npop + CNT_W'(1);
                    n_count = r_count - CNT_W'(1);
                    n_pos   = '0;
                    n_state = mhtq_pkg::S_REM_DOWN;
                end else begin
                    n_iter  = '0;
                    n_state = mhtq_pkg::S_RA_RD;
                end
            end
            mhtq_pkg::S_RA_RD: begin
                n_state = mhtq_pkg::S_RA_INS;
            end
            mhtq_pkg::S_RA_INS: begin
                if (w_rd.interval != '0) begin
                    n_pos     = IDX_W'(r_count);
                    n_count   = r_count + CNT_W'(1);
                    n_next_id = r_next_id + mhtq_pkg::ID_W'(1);
                    n_state   = mhtq_pkg::S_RA_UP;
                end else if (w_iter_last) begin
                    n_iter  = '0;
                    n_state = mhtq_pkg::S_EM_RD;
                end else begin
                    n_iter  = r_iter + IDX_W'(1);
                    n_state = mhtq_pkg::S_RA_RD;
                end
            end
            mhtq_pkg::S_RA_UP: begin
                priority if (w_any_up) begin
                    n_pos = w_par_pos;
                end else if (w_iter_last) begin
                    n_iter  = '0;
                    n_state = mhtq_pkg::S_EM_RD;
                end else begin
                    n_iter  = r_iter + IDX_W'(1);
                    n_state = mhtq_pkg::S_RA_RD;
                end
            end
            mhtq_pkg::S_EM_RD: begin
                n_state = mhtq_pkg::S_EM_OUT;
            end
            mhtq_pkg::S_EM_OUT: begin
                if (w_iter_last) begin
                    n_state = mhtq_pkg::S_IDLE;
                end else begin
                    n_iter  = r_iter + IDX_W'(1);
                    n_state = mhtq_pkg::S_EM_RD;
                end
            end
            mhtq_pkg::S_REPORT: begin
                n_state = mhtq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_cell_op     = mhtq_pkg::OP_HOLD;
        w_cell_pos    = r_pos;
        w_log_we      = 1'b0;
        w_wr.id       = r_next_id;
        w_wr.deadline = i_deadline;
        w_wr.interval = i_interval;
        w_wr.ctx      = i_context_req;
        n_o_strobe    = 1'b0;
        n_o_status    = r_status;
        n_o_id        = r_id;
        n_o_fired_dl  = '0;
        n_o_fired_ctx = '0;
        n_o_next_dl   = w_empty ? '1 : w_root.deadline;
        n_o_armed     = !w_empty;
        n_o_last      = 1'b1;
        unique case (r_state)
            mhtq_pkg::S_IDLE: begin
                w_cell_pos = IDX_W'(r_count);
                if (start) begin
                    unique case (i_kind)
                        mhtq_pkg::KIND_ADD: begin
                            if (w_full) begin
                                n_o_strobe = 1'b1;
                                n_o_status = mhtq_pkg::ST_FULL;
                                n_o_id     = '0;
                            end else begin
                                w_cell_op = mhtq_pkg::OP_WRITE;
                            end
                        end
                        mhtq_pkg::KIND_DEL: begin
                        end
                        default: begin
                            if (w_empty) begin
                                n_o_strobe = 1'b1;
                                n_o_status = mhtq_pkg::ST_NONE_DUE;
                                n_o_id     = '0;
                            end
                        end
                    endcase
                end
            end
            mhtq_pkg::S_ADD_UP, mhtq_pkg::S_REM_UP, mhtq_pkg::S_RA_UP: begin
                w_cell_op = mhtq_pkg::OP_UP;
            end
            mhtq_pkg::S_DEL_PICK: begin
                w_cell_pos = w_match_idx;
                if (w_any_match) begin
                    w_cell_op = mhtq_pkg::OP_MOVE;
                end
            end
            mhtq_pkg::S_REM_DOWN: begin
                w_cell_op = mhtq_pkg::OP_DOWN;
            end
            mhtq_pkg::S_FIRE_POP: begin
                w_cell_pos = '0;
                if (w_pop_due) begin
                    w_cell_op = mhtq_pkg::OP_MOVE;
                    w_log_we  = 1'b1;
                end
            end
            mhtq_pkg::S_RA_INS: begin
                w_cell_pos    = IDX_W'(r_count);
                w_wr.deadline = w_sat;
                w_wr.interval = w_rd.interval;
                w_wr.ctx      = w_rd.ctx;
                if (w_rd.interval != '0) begin
                    w_cell_op = mhtq_pkg::OP_WRITE;
                end
            end
            mhtq_pkg::S_EM_OUT: begin
                n_o_strobe    = 1'b1;
                n_o_status    = mhtq_pkg::ST_FIRED;
                n_o_id        = w_rd.id;
                n_o_fired_dl  = w_rd.deadline;
                n_o_fired_ctx = w_rd.ctx;
                n_o_last      = w_iter_last;
            end
            mhtq_pkg::S_REPORT: begin
                n_o_strobe = 1'b1;
            end
            mhtq_pkg::S_RA_RD, mhtq_pkg::S_EM_RD: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mhtq_pkg::S_IDLE;
            r_count    <= '0;
            r_next_id  <= '0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_next_id  <= n_next_id;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos         <= n_pos;
        r_pos0        <= n_pos0;
        r_is_fire     <= n_is_fire;
        r_earliest    <= n_earliest;
        r_npop        <= n_npop;
        r_iter        <= n_iter;
        r_status      <= n_status;
        r_id          <= n_id;
        r_match       <= n_match;
        r_o_status    <= n_o_status;
        r_o_id        <= n_o_id;
        r_o_fired_dl  <= n_o_fired_dl;
        r_o_fired_ctx <= n_o_fired_ctx;
        r_o_next_dl   <= n_o_next_dl;
        r_o_armed     <= n_o_armed;
        r_o_last      <= n_o_last;
    end

    assign busy             = (r_state != mhtq_pkg::S_IDLE);
    assign o_strobe         = r_o_strobe;
    assign o_status         = r_o_status;
    assign o_timer_id       = r_o_id;
    assign o_fired_deadline = r_o_fired_dl;
    assign o_fired_context  = r_o_fired_ctx;
    assign o_next_deadline  = r_o_next_dl;
    assign o_armed          = r_o_armed;
    assign o_last           = r_o_last;

    a_single_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_up_vec, w_l_vec, w_r_vec}))
        else $error("More than one cell swapped in a sift step.");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == mhtq_pkg::KIND_ADD) && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Accepted add did not grow the queue by one entry.");

    a_first_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mhtq_pkg::S_FIRE_POP) && $past(r_state == mhtq_pkg::S_IDLE))
        |-> w_pop_due)
        else $error("Fire item found no due timer at the root.");

    a_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_armed) |-> (o_next_deadline == '1))
        else $error("Disarmed word carries a next deadline.");

    a_emit_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhtq_pkg::S_EM_OUT) |-> (r_npop != '0))
        else $error("Fired word emitted with an empty pop log.");

endmodule

// ----- sv/mhtq_cell.sv -----
// ----------------------------------------------------------------------------
// Min-heap timer queue: heap cell
// Holds one heap slot, loads it on a write or a move, and exchanges it with its
// parent or children when the pointer rests on it during a sift step.
// ----------------------------------------------------------------------------
module mhtq_cell (
    input  logic                       i_clk,
    input  mhtq_pkg::t_cell_ctrl       i_ctrl,
    input  mhtq_pkg::t_cell_link       i_link,
    input  mhtq_pkg::t_entry           i_wr,
    input  mhtq_pkg::t_entry           i_tail,
    input  mhtq_pkg::t_entry           i_parent,
    input  mhtq_pkg::t_entry           i_left,
    input  mhtq_pkg::t_entry           i_right,
    input  logic [mhtq_pkg::ID_W-1:0]  i_target_id,
    output mhtq_pkg::t_entry           o_entry,
    output mhtq_pkg::t_cell_stat       o_stat
);

    mhtq_pkg::t_entry          r_entry;
    mhtq_pkg::t_entry          n_entry;
    logic                      w_act_up;
    logic                      w_act_down;
    logic                      w_up;
    logic                      w_left_lt;
    logic                      w_take_l;
    logic                      w_take_r;
    logic [mhtq_pkg::DL_W-1:0] w_min_dl;

    assign w_act_up   = i_ctrl.sel && i_ctrl.vld && (i_ctrl.op == mhtq_pkg::OP_UP);
    assign w_act_down = i_ctrl.sel && i_ctrl.vld && (i_ctrl.op == mhtq_pkg::OP_DOWN);
    assign w_up       = w_act_up && !i_ctrl.root && (r_entry.deadline < i_parent.deadline);
    assign w_left_lt  = w_act_down && i_link.vld_l && (r_entry.deadline > i_left.deadline);
    assign w_min_dl   = w_left_lt ? i_left.deadline : r_entry.deadline;
    assign w_take_r   = w_act_down && i_link.vld_r && (w_min_dl > i_right.deadline);
    assign w_take_l   = w_left_lt && !w_take_r;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            mhtq_pkg::OP_HOLD: begin
            end
            mhtq_pkg::OP_WRITE: begin
                if (i_ctrl.sel) begin
                    n_entry = i_wr;
                end
            end
            mhtq_pkg::OP_MOVE: begin
                if (i_ctrl.sel) begin
                    n_entry = i_tail;
                end
            end
            mhtq_pkg::OP_UP: begin
                priority if (w_up) begin
                    n_entry = i_parent;
                end else if (i_link.up_l) begin
                    n_entry = i_left;
                end else if (i_link.up_r) begin
                    n_entry = i_right;
                end
            end
            mhtq_pkg::OP_DOWN: begin
                priority if (w_take_l) begin
                    n_entry = i_left;
                end else if (w_take_r) begin
                    n_entry = i_right;
                end else if (i_link.down) begin
                    n_entry = i_parent;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry       = r_entry;
    assign o_stat.vld    = i_ctrl.vld;
    assign o_stat.up     = w_up;
    assign o_stat.take_l = w_take_l;
    assign o_stat.take_r = w_take_r;
    assign o_stat.match  = i_ctrl.vld && (r_entry.id == i_target_id);

endmodule

// ----- sv/mhtq_pop_log.sv -----
// ----------------------------------------------------------------------------
// Min-heap timer queue: pop log
// Records the timers popped by one fire item for re-adding and reporting.
// ----------------------------------------------------------------------------
module mhtq_pop_log #(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  mhtq_pkg::t_entry         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output mhtq_pkg::t_entry         o_rd_data
);

    mhtq_pkg::t_entry r_mem [DEPTH];
    mhtq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- test/min_heap_timer_queue_top_test.sv -----
// ----------------------------------------------------------------------------
// Min-heap timer queue: top-level testbench
// Drives add, delete and fire commands through the start/busy handshake and
// predicts every result word with a behavioural heap kept in a scoreboard.
// Each strobed word is checked field by field against the oldest prediction.
// Stimulus is a directed opening followed by random rounds that fill the queue,
// mix operations, drain it and inject unstructured commands.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mhtq_pkg::*;

    localparam int QDEPTH = 32;
    localparam int RANDOM_ITEMS = 170;
    localparam int QUIET_TAIL = 30;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 600;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   timer_id;
        logic [DL_W-1:0]   fired_deadline;
        logic [CTX_W-1:0]  fired_context;
        logic [DL_W-1:0]   next_deadline;
        logic              armed;
        logic              last;
    } timer_word_t;

    typedef enum int {ACT_ADD, ACT_DEL, ACT_FIRE, ACT_NOISE} act_t;
    typedef enum int {ROUND_FILL, ROUND_MIX, ROUND_DRAIN, ROUND_NOISE} round_t;

    class timer_queue_model;
        logic [DL_W-1:0]  heap_dl [QDEPTH];
        logic [DL_W-1:0]  heap_iv [QDEPTH];
        logic [ID_W-1:0]  heap_id [QDEPTH];
        logic [CTX_W-1:0] heap_ctx [QDEPTH];
        int               heap_len;
        logic [ID_W-1:0]  next_id;
        timer_word_t      expected_words[$];
        int mismatches, words_checked, longest_burst;
        int adds, deletes, fires, spare_fires, refused, fired_words;

        function new();
            heap_len = 0;
            next_id = '0;
            mismatches = 0;
            words_checked = 0;
            longest_burst = 0;
            adds = 0;
            deletes = 0;
            fires = 0;
            spare_fires = 0;
            refused = 0;
            fired_words = 0;
        endfunction

        function void swap_entries(int a, int b);
            logic [DL_W-1:0]  d;
            logic [DL_W-1:0]  v;
            logic [ID_W-1:0]  i;
            logic [CTX_W-1:0] c;
            d = heap_dl[a];  heap_dl[a] = heap_dl[b];  heap_dl[b] = d;
            v = heap_iv[a];  heap_iv[a] = heap_iv[b];  heap_iv[b] = v;
            i = heap_id[a];  heap_id[a] = heap_id[b];  heap_id[b] = i;
            c = heap_ctx[a]; heap_ctx[a] = heap_ctx[b]; heap_ctx[b] = c;
        endfunction

        function void sift_up(int p);
            int parent;
            while (p > 0) begin
                parent = (p - 1) / 2;
                if (!(heap_dl[p] < heap_dl[parent])) break;
                swap_entries(p, parent);
                p = parent;
            end
        endfunction

        function logic [ID_W-1:0] insert(logic [DL_W-1:0] dl, logic [DL_W-1:0] iv,
                                         logic [CTX_W-1:0] ctx);
            logic [ID_W-1:0] id;
            id = next_id;
            next_id = next_id + 1'b1;
            heap_dl[heap_len] = dl;
            heap_iv[heap_len] = iv;
            heap_id[heap_len] = id;
            heap_ctx[heap_len] = ctx;
            heap_len++;
            sift_up(heap_len - 1);
            return id;
        endfunction

        function void remove_at(int p);
            int l, r, m;
            heap_len--;
            if (p < heap_len) begin
                heap_dl[p] = heap_dl[heap_len];
                heap_iv[p] = heap_iv[heap_len];
                heap_id[p] = heap_id[heap_len];
                heap_ctx[p] = heap_ctx[heap_len];
                sift_up(p);
                while (1) begin
                    l = 2 * p + 1;
                    r = l + 1;
                    m = p;
                    if (l < heap_len && heap_dl[m] > heap_dl[l]) m = l;
                    if (r < heap_len && heap_dl[m] > heap_dl[r]) m = r;
                    if (m == p) break;
                    swap_entries(p, m);
                    p = m;
                end
            end
        endfunction

        function timer_word_t make_word(logic [STAT_W-1:0] st, logic [ID_W-1:0] id,
                                        logic [DL_W-1:0] fdl, logic [CTX_W-1:0] fctx);
            timer_word_t w;
            w = '0;
            w.status = st;
            w.timer_id = id;
            w.fired_deadline = fdl;
            w.fired_context = fctx;
            return w;
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [DL_W-1:0] dl,
                                logic [DL_W-1:0] iv, logic [CTX_W-1:0] ctx,
                                logic [ID_W-1:0] tid);
            timer_word_t      burst[$];
            timer_word_t      w;
            logic [DL_W-1:0]  earliest;
            logic [DL_W:0]    sum;
            logic [DL_W-1:0]  re_dl[$];
            logic [DL_W-1:0]  re_iv[$];
            logic [CTX_W-1:0] re_ctx[$];
            int               slot;
            if (kind == KIND_ADD) begin
                adds++;
                if (heap_len >= QDEPTH) begin
                    refused++;
                    burst.push_back(make_word(ST_FULL, '0, '0, '0));
                end else begin
                    burst.push_back(make_word(ST_ADDED, insert(dl, iv, ctx), '0, '0));
                end
            end else if (kind == KIND_DEL) begin
                deletes++;
                slot = -1;
                for (int p = 0; p < heap_len; p++) begin
                    if (slot < 0 && heap_id[p] == tid) slot = p;
                end
                if (slot >= 0) begin
                    remove_at(slot);
                    burst.push_back(make_word(ST_DELETED, tid, '0, '0));
                end else begin
                    burst.push_back(make_word(ST_NO_ID, tid, '0, '0));
                end
            end else begin
                fires++;
                if (kind == KIND_SPARE) spare_fires++;
                if (heap_len == 0) begin
                    burst.push_back(make_word(ST_NONE_DUE, '0, '0, '0));
                end else begin
                    earliest = heap_dl[0];
                    while (heap_len != 0 && heap_dl[0] == earliest) begin
                        burst.push_back(make_word(ST_FIRED, heap_id[0], heap_dl[0],
                                                  heap_ctx[0]));
                        if (heap_iv[0] != '0) begin
                            sum = {1'b0, heap_dl[0]} + {1'b0, heap_iv[0]};
                            re_dl.push_back(sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0]);
                            re_iv.push_back(heap_iv[0]);
                            re_ctx.push_back(heap_ctx[0]);
                        end
                        remove_at(0);
                    end
                    foreach (re_dl[i]) begin
                        if (heap_len < QDEPTH) void'(insert(re_dl[i], re_iv[i], re_ctx[i]));
                    end
                end
            end
            foreach (burst[k]) begin
                w = burst[k];
                w.next_deadline = (heap_len != 0) ? heap_dl[0] : {DL_W{1'b1}};
                w.armed = (heap_len != 0);
                w.last = (k == burst.size() - 1);
                expected_words.push_back(w);
            end
            if (burst.size() > longest_burst) longest_burst = burst.size();
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(timer_word_t got);
            timer_word_t want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: status %0d, timer_id %0h", got.status, got.timer_id);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (want.status == ST_FIRED) fired_words++;
            check_field("status", want.status, got.status);
            check_field("timer_id", want.timer_id, got.timer_id);
            check_field("fired_deadline", want.fired_deadline, got.fired_deadline);
            check_field("fired_context", want.fired_context, got.fired_context);
            check_field("next_deadline", want.next_deadline, got.next_deadline);
            check_field("armed", want.armed, got.armed);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] i_kind = '0;
    logic [DL_W-1:0]   i_deadline = '0;
    logic [DL_W-1:0]   i_interval = '0;
    logic [CTX_W-1:0]  i_context_req = '0;
    logic [ID_W-1:0]   i_target_id = '0;
    logic              o_strobe;
    logic [STAT_W-1:0] o_status;
    logic [ID_W-1:0]   o_timer_id;
    logic [DL_W-1:0]   o_fired_deadline;
    logic [CTX_W-1:0]  o_fired_context;
    logic [DL_W-1:0]   o_next_deadline;
    logic              o_armed;
    logic              o_last;

    timer_queue_model ledger;
    int               issued = 0;
    bit               gaps_on = 1'b1;
    bit               closing = 1'b0;
    logic [DL_W-1:0]  dl_pool [4];
    int               pool_size = 1;

    min_heap_timer_queue_top #(.QUEUE_DEPTH(QDEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_deadline      (i_deadline),
        .i_interval      (i_interval),
        .i_context_req   (i_context_req),
        .i_target_id     (i_target_id),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_timer_id      (o_timer_id),
        .o_fired_deadline(o_fired_deadline),
        .o_fired_context (o_fired_context),
        .o_next_deadline (o_next_deadline),
        .o_armed         (o_armed),
        .o_last          (o_last)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            ledger.check_word({o_status, o_timer_id, o_fired_deadline, o_fired_context,
                               o_next_deadline, o_armed, o_last});
        end
    end

    function automatic logic [DL_W-1:0] rand_dl();
        logic [63:0] r;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return DL_W'($urandom_range(0, 1000));
            default: begin
                r = {$urandom(), $urandom()};
                return r[DL_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [DL_W-1:0] rand_interval();
        case ($urandom_range(0, 5))
            0, 1, 2: return '0;
            3: return DL_W'($urandom_range(1, 500));
            4: return '1;
            default: return rand_dl();
        endcase
    endfunction

    function automatic logic [CTX_W-1:0] rand_context();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [31:0] r;
        r = $urandom();
        return r[ID_W-1:0];
    endfunction

    function automatic logic [DL_W-1:0] pick_deadline();
        if ($urandom_range(0, 3) != 0) return dl_pool[$urandom_range(0, pool_size - 1)];
        return rand_dl();
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DL_W-1:0] dl,
                             input logic [DL_W-1:0] iv, input logic [CTX_W-1:0] ctx,
                             input logic [ID_W-1:0] tid);
        i_kind <= kind;
        i_deadline <= dl;
        i_interval <= iv;
        i_context_req <= ctx;
        i_target_id <= tid;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.note_item(kind, dl, iv, ctx, tid);
    endtask

    task automatic pace();
        if (gaps_on && !closing && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic drive_random(input act_t act);
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   tid;
        logic [31:0]       r;
        case (act)
            ACT_ADD: send_item(KIND_ADD, pick_deadline(), rand_interval(), rand_context(),
                               rand_id());
            ACT_DEL: begin
                tid = rand_id();
                if (ledger.heap_len > 0 && $urandom_range(0, 3) != 0)
                    tid = ledger.heap_id[$urandom_range(0, ledger.heap_len - 1)];
                send_item(KIND_DEL, rand_dl(), rand_dl(), rand_context(), tid);
            end
            ACT_FIRE: begin
                kind = KIND_FIRE;
                if ($urandom_range(0, 3) == 0) kind = KIND_SPARE;
                send_item(kind, rand_dl(), rand_dl(), rand_context(), rand_id());
            end
            default: begin
                r = $urandom();
                send_item(r[KIND_W-1:0], rand_dl(), rand_dl(), $urandom(), rand_id());
            end
        endcase
        issued++;
        closing = (issued >= RANDOM_ITEMS - QUIET_TAIL);
        pace();
    endtask

    task automatic directed(input logic [KIND_W-1:0] kind, input logic [DL_W-1:0] dl,
                            input logic [DL_W-1:0] iv, input logic [CTX_W-1:0] ctx,
                            input logic [ID_W-1:0] tid);
        send_item(kind, dl, iv, ctx, tid);
        pace();
    endtask

    initial begin
        int     n;
        int     guard;
        int     pick;
        round_t round;
        ledger = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed(KIND_FIRE, '0, '0, '0, '0);
        directed(KIND_DEL, '0, '0, '0, '1);
        directed(KIND_ADD, 48'd10, '0, 32'h0000_0000, '0);
        directed(KIND_ADD, 48'd50, '0, 32'hFFFF_FFFF, '0);
        directed(KIND_ADD, 48'd20, '0, 32'h1234_5678, '0);
        directed(KIND_ADD, 48'd60, '0, 32'h0000_0001, '0);
        directed(KIND_ADD, 48'd70, '0, 32'h8000_0000, '0);
        directed(KIND_ADD, 48'd25, '0, 32'hA5A5_A5A5, '0);
        directed(KIND_ADD, 48'd30, '0, 32'h5A5A_5A5A, '0);
        directed(KIND_DEL, '0, '0, '0, 31'd3);
        directed(KIND_DEL, '0, '0, '0, 31'd0);
        directed(KIND_DEL, '0, '0, '0, 31'd0);
        directed(KIND_ADD, '0, '1, 32'hFFFF_FFFF, '0);
        directed(KIND_ADD, '1, '1, '0, '0);
        directed(KIND_ADD, '1, 48'd1, 32'hDEAD_BEEF, '0);
        directed(KIND_ADD, 48'd20, 48'd5, 32'hCAFE_F00D, '0);
        directed(KIND_SPARE, '0, '0, '0, '0);
        repeat (6) directed(KIND_FIRE, '0, '0, '0, '0);
        directed(KIND_FIRE, '1, '1, '1, '1);

        while (issued < RANDOM_ITEMS) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            pool_size = $urandom_range(1, 4);
            foreach (dl_pool[i]) dl_pool[i] = rand_dl();
            round = round_t'($urandom_range(0, 3));
            case (round)
                ROUND_FILL: begin
                    n = QDEPTH - ledger.heap_len + $urandom_range(1, 2);
                    repeat (n) drive_random(ACT_ADD);
                end
                ROUND_MIX: begin
                    repeat ($urandom_range(10, 25)) begin
                        pick = $urandom_range(0, 7);
                        if (pick < 4) drive_random(ACT_ADD);
                        else if (pick < 6) drive_random(ACT_DEL);
                        else drive_random(ACT_FIRE);
                    end
                end
                ROUND_DRAIN: begin
                    n = $urandom_range(8, 40);
                    while (n > 0 && ledger.heap_len > 0) begin
                        drive_random(ACT_FIRE);
                        n--;
                    end
                    drive_random(ACT_FIRE);
                end
                default: repeat ($urandom_range(4, 10)) drive_random(ACT_NOISE);
            endcase
        end
        start <= 1'b0;

        guard = 0;
        while (ledger.expected_words.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.expected_words.size() != 0) begin
            $error("%0d expected words never arrived", ledger.expected_words.size());
            ledger.mismatches++;
        end

        $display("Checked %0d result words (%0d firings) from %0d adds, %0d deletes, %0d fires",
                 ledger.words_checked, ledger.fired_words, ledger.adds, ledger.deletes,
                 ledger.fires);
        $display("Fires on the spare kind: %0d, adds refused while full: %0d, longest burst: %0d",
                 ledger.spare_fires, ledger.refused, ledger.longest_burst);
        if (ledger.mismatches == 0) begin
            $display("PASS min_heap_timer_queue_top");
        end else begin
            $display("FAIL min_heap_timer_queue_top");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL min_heap_timer_queue_top");
        $finish;
    end

endmodule

// ----- min_heap_timer_queue_top.f -----
sv/mhtq_pkg.sv
sv/mhtq_cell.sv
sv/mhtq_pop_log.sv
sv/min_heap_timer_queue_top.sv
test/min_heap_timer_queue_top_test.sv
